### rtl/core/bmam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmam_pkg
// shared types, widths and codes of the battery moving-average monitor
// ----------------------------------------------------------------------------
package bmam_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int SUM_W       = 18;
  localparam int REF_W       = 16;
  localparam int RATIO_W     = 8;
  localparam int OFFSET_W    = 16;
  localparam int MV_W        = 24;
  localparam int DV_W        = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam int WINDOW_SIZE_DEF = 8;

  // serial divider sizing: widest dividend is the divider ratio product
  localparam int DIV_W     = MV_W;
  localparam int DIVISOR_W = RATIO_W;
  localparam int CNT_W     = $clog2(DIV_W + 1);

  // constant divisions as reciprocal multiplications, exact over the whole
  // dividend range: floor(x / d) = (x * ceil(2**s / d)) >> s
  localparam longint unsigned ADC_FULL_SCALE = 4095;
  localparam longint unsigned DECIV_DIVISOR  = 100;

  localparam int ADC_SHIFT   = SAMPLE_W + REF_W + 12;
  localparam int ADC_RECIP_W = 29;
  localparam logic [ADC_RECIP_W-1:0] ADC_RECIP =
    ADC_RECIP_W'(((64'd1 << ADC_SHIFT) + ADC_FULL_SCALE - 1) / ADC_FULL_SCALE);

  localparam int DV_SHIFT   = MV_W + 1 + 7;
  localparam int DV_RECIP_W = 26;
  localparam logic [DV_RECIP_W-1:0] DV_RECIP =
    DV_RECIP_W'(((64'd1 << DV_SHIFT) + DECIV_DIVISOR - 1) / DECIV_DIVISOR);

  localparam logic [MV_W:0]        ROUND_HALF     = (MV_W + 1)'(50);
  localparam logic [MV_W-1:0]      MV_MAX         = '1;
  localparam logic [DV_W-1:0]      DV_MAX         = '1;

  localparam logic [REF_W-1:0]    REFERENCE_RESET   = REF_W'(3300);
  localparam logic [RATIO_W-1:0]  NUMERATOR_RESET   = RATIO_W'(1);
  localparam logic [RATIO_W-1:0]  DENOMINATOR_RESET = RATIO_W'(1);
  localparam logic [OFFSET_W-1:0] OFFSET_RESET      = '0;

  localparam logic [CFG_INDEX_W-1:0] CFG_REFERENCE_MV   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_DIV_NUMERATOR  = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_DIV_DENOMINATOR = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_MV      = CFG_INDEX_W'(3);

  localparam logic REQ_NORMAL = 1'b0;
  localparam logic REQ_PRIME  = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [SAMPLE_W-1:0] sample;
  } bmam_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average_raw;
    logic [MV_W-1:0]     battery_mv;
    logic [DV_W-1:0]     battery_deciv;
  } bmam_out_t;

  typedef struct packed {
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
    logic [CNT_W-1:0]     bits;
  } bmam_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } bmam_div_rsp_t;

endpackage

### rtl/core/bmam_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmam_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bmam_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/bmam_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmam_div
// restoring divider, one quotient bit per cycle over a chosen number of bits
// ----------------------------------------------------------------------------
module bmam_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  bmam_pkg::bmam_div_req_t req,
  output bmam_pkg::bmam_div_rsp_t rsp
);
  import bmam_pkg::*;

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] divisor;
  logic [DIV_W-1:0]     quo;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic                 done;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic               fits;

  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem     <= '0;
        // align the used dividend bits at the top of the shift register
        quo     <= req.dividend << (CNT_W'(DIV_W) - req.bits);
        divisor <= req.divisor;
        cnt     <= req.bits;
        busy    <= 1'b1;
      end else if (busy) begin
        rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        quo <= {quo[DIV_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

### rtl/core/battery_moving_average_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_moving_average_monitor
// boxcar average of battery adc samples with millivolt and decivolt outputs
// ----------------------------------------------------------------------------
// One transaction at a time: a sample is accepted only while the sequencer
// is idle, and the sequencer returns to idle once the result has been moved
// into the output register. Most of a normal sample's time goes to the serial
// divide by the configured divider denominator, one quotient bit per cycle
// over 24 bits; the divisions by the window size, by full scale and by 100
// for decivolts are reciprocal multiplications, each in its own state, and a
// prime also writes every window slot, one per cycle. The window lives in a
// ram with registered read; per-slot valid flags make the ring read as zero
// after reset, so no clearing pass runs. A finished result is held in an
// output register while the next sample may already be taken; the following
// result then waits until that register is free. Configuration writes are
// always accepted.
module battery_moving_average_monitor #(
  parameter int WINDOW_SIZE = bmam_pkg::WINDOW_SIZE_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  bmam_pkg::bmam_in_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output bmam_pkg::bmam_out_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bmam_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [bmam_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import bmam_pkg::*;

  localparam int SLOT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam logic [SLOT_W-1:0]    LAST_SLOT = SLOT_W'(WINDOW_SIZE - 1);
  localparam logic [SUM_W-1:0]     WIN_MULT  = SUM_W'(WINDOW_SIZE);

  // sum / WINDOW_SIZE as a reciprocal multiplication, exact for 18-bit sums
  localparam int AVG_SHIFT   = SUM_W + $clog2(WINDOW_SIZE);
  localparam int AVG_RECIP_W = SUM_W + 1;
  localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
    AVG_RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE));
  localparam int ADC_PROD_W = SAMPLE_W + REF_W + ADC_RECIP_W;
  localparam int DV_PROD_W  = MV_W + 1 + DV_RECIP_W;

  typedef enum logic [3:0] {
    IDLE, PRIME_FILL, UPDATE, AVG_DIV, MUL_REF, ADC_DIV, MUL_NUM,
    DEN_GO, DEN_WAIT, MV_ADD, DV_DIV, DONE
  } state_t;

  state_t state;

  // configuration
  logic [REF_W-1:0]    reference_mv;
  logic [RATIO_W-1:0]  divider_numerator;
  logic [RATIO_W-1:0]  divider_denominator;
  logic [OFFSET_W-1:0] offset_mv;

  // window state
  logic [SUM_W-1:0]       window_sum;
  logic [SLOT_W-1:0]      write_slot;
  logic [SAMPLE_W-1:0]    average_value;
  logic [WINDOW_SIZE-1:0] slot_valid;
  logic                   old_valid;
  logic [SLOT_W-1:0]      fill;
  logic [SAMPLE_W-1:0]    smp;

  // conversion datapath
  logic [SAMPLE_W+REF_W-1:0] prod_ref;
  logic [DIV_W-1:0]          prod;
  logic [REF_W-1:0]          adc;
  logic [MV_W-1:0]           mv_q;
  logic [MV_W-1:0]           mv;
  logic [DV_W-1:0]           dv;

  logic [SLOT_W-1:0]            slot_eff;
  logic [SLOT_W-1:0]            slot_adv;
  logic                         in_accept;
  logic [SAMPLE_W-1:0]          old_sample;
  logic [SUM_W-1:0]             sum_upd;
  logic [SUM_W+AVG_RECIP_W-1:0] avg_prod;
  logic [SAMPLE_W+REF_W-1:0]    mul_ref;
  logic [ADC_PROD_W-1:0]        adc_prod;
  logic [REF_W+RATIO_W-1:0]     mul_num;
  logic [MV_W:0]                mv_sum;
  logic [MV_W:0]                mv_round;
  logic [DV_PROD_W-1:0]         dv_prod;
  logic [RATIO_W-1:0]           den_eff;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic                ram_re;
  logic [SAMPLE_W-1:0] ram_rdata;

  logic          div_start;
  bmam_div_req_t div_req;
  bmam_div_rsp_t div_rsp;

  assign in_ready  = (state == IDLE);
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    // a slot that is out of range is taken as the first one
    slot_eff   = (int'(write_slot) >= WINDOW_SIZE) ? '0 : write_slot;
    slot_adv   = (slot_eff == LAST_SLOT) ? '0 : slot_eff + 1'b1;
    old_sample = old_valid ? ram_rdata : '0;
    sum_upd    = window_sum - SUM_W'(old_sample) + SUM_W'(smp);
    avg_prod   = window_sum * AVG_RECIP;
    mul_ref    = average_value * reference_mv;
    adc_prod   = prod_ref * ADC_RECIP;
    mul_num    = adc * divider_numerator;
    mv_sum     = {1'b0, mv_q} + (MV_W + 1)'(offset_mv);
    mv_round   = {1'b0, mv} + ROUND_HALF;
    dv_prod    = mv_round * DV_RECIP;
    den_eff    = (divider_denominator == '0) ? RATIO_W'(1) : divider_denominator;
  end

  // ram port control
  assign ram_re    = in_accept && (in_data.req_type == REQ_NORMAL);
  assign ram_we    = (state == PRIME_FILL) || (state == UPDATE);
  assign ram_waddr = (state == PRIME_FILL) ? fill : slot_eff;

  bmam_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_SIZE)
  ) u_window_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (smp),
    .re    (ram_re),
    .raddr (slot_eff),
    .rdata (ram_rdata)
  );

  // divider request follows the sequencer state
  always_comb begin
    div_start = 1'b0;
    div_req   = '0;
    case (state)
      DEN_GO: begin
        div_start        = 1'b1;
        div_req.dividend = prod;
        div_req.divisor  = DIVISOR_W'(den_eff);
        div_req.bits     = CNT_W'(MV_W);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  bmam_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_mv        <= REFERENCE_RESET;
      divider_numerator   <= NUMERATOR_RESET;
      divider_denominator <= DENOMINATOR_RESET;
      offset_mv           <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REFERENCE_MV:    reference_mv        <= cfg_data[REF_W-1:0];
        CFG_DIV_NUMERATOR:   divider_numerator   <= cfg_data[RATIO_W-1:0];
        CFG_DIV_DENOMINATOR: divider_denominator <= cfg_data[RATIO_W-1:0];
        CFG_OFFSET_MV:       offset_mv           <= cfg_data[OFFSET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      window_sum    <= '0;
      write_slot    <= '0;
      average_value <= '0;
      slot_valid    <= '0;
      out_valid     <= 1'b0;
    end else begin
      // in DONE the output register is handled below
      if (out_valid && out_ready && (state != DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_accept) begin
            smp <= in_data.sample;
            if (in_data.req_type == REQ_PRIME) begin
              window_sum    <= SUM_W'(WIN_MULT * SUM_W'(in_data.sample));
              average_value <= in_data.sample;
              write_slot    <= '0;
              fill          <= '0;
              state         <= PRIME_FILL;
            end else begin
              old_valid <= slot_valid[slot_eff];
              state     <= UPDATE;
            end
          end
        end
        PRIME_FILL: begin
          slot_valid[fill] <= 1'b1;
          fill             <= fill + 1'b1;
          if (fill == LAST_SLOT) begin
            state <= MUL_REF;
          end
        end
        UPDATE: begin
          window_sum           <= sum_upd;
          slot_valid[slot_eff] <= 1'b1;
          write_slot           <= slot_adv;
          state                <= AVG_DIV;
        end
        AVG_DIV: begin
          average_value <= avg_prod[AVG_SHIFT +: SAMPLE_W];
          state         <= MUL_REF;
        end
        MUL_REF: begin
          prod_ref <= mul_ref;
          state    <= ADC_DIV;
        end
        ADC_DIV: begin
          adc   <= adc_prod[ADC_SHIFT +: REF_W];
          state <= MUL_NUM;
        end
        MUL_NUM: begin
          prod  <= DIV_W'(mul_num);
          state <= DEN_GO;
        end
        DEN_GO: state <= DEN_WAIT;
        DEN_WAIT: begin
          if (div_rsp.done) begin
            mv_q  <= div_rsp.quotient[MV_W-1:0];
            state <= MV_ADD;
          end
        end
        MV_ADD: begin
          mv    <= mv_sum[MV_W] ? MV_MAX : mv_sum[MV_W-1:0];
          state <= DV_DIV;
        end
        DV_DIV: begin
          dv    <= (|dv_prod[DV_PROD_W-1:DV_SHIFT+DV_W]) ?
                   DV_MAX : dv_prod[DV_SHIFT +: DV_W];
          state <= DONE;
        end
        DONE: begin
          // wait for the output register to free up
          if (!out_valid || out_ready) begin
            out_data.average_raw   <= average_value;
            out_data.battery_mv    <= mv;
            out_data.battery_deciv <= dv;
            out_valid              <= 1'b1;
            state                  <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

### rtl/core/bmam_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmam_checker
// port-level checks of the battery moving-average monitor
// ----------------------------------------------------------------------------
module bmam_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bmam_pkg::bmam_out_t out_data
);
  import bmam_pkg::*;

  // a held result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one transaction at a time: the block is busy right after an accept
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous transaction in flight");

  // decivolts round to zero exactly below half a tenth of a volt
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.battery_deciv == '0) ==
                   (out_data.battery_mv < MV_W'(50))))
    else $error("decivolt rounding inconsistent with millivolts");

endmodule

bind battery_moving_average_monitor bmam_checker u_bmam_checker (.*);

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the battery moving-average monitor against a cycle-free predictor
// of the window, the running sum and the millivolt / decivolt conversions.
// directed samples and register extremes come first, then random phases
// with changing settings and random idling on both the sample and result
// channels; every result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  import bmam_pkg::*;

  localparam int WINDOW_SIZE   = WINDOW_SIZE_DEF;
  localparam int STALL_LIMIT   = 5000;
  localparam int TAIL_CYCLES   = 200;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 60;

  localparam longint unsigned FULL_SCALE = 4095;
  localparam longint unsigned ROUNDING   = 50;
  localparam longint unsigned DECI_STEP  = 100;
  localparam longint unsigned MV_LIMIT   = 64'hFF_FFFF;
  localparam longint unsigned DV_LIMIT   = 64'hFFFF;

  // indexes past the end of the register list
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_FIRST = CFG_INDEX_W'(4);
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LAST  = '1;

  class window_average_tracker;
    logic [SAMPLE_W-1:0] window_mem [WINDOW_SIZE];
    logic [SUM_W-1:0]    running_sum;
    logic [5:0]          next_slot;
    logic [SAMPLE_W-1:0] average_q;
    logic [REF_W-1:0]    reference_q;
    logic [RATIO_W-1:0]  numerator_q;
    logic [RATIO_W-1:0]  denominator_q;
    logic [OFFSET_W-1:0] offset_q;
    bmam_out_t           expected_readings [$];
    int                  mismatches;
    int                  readings_checked;
    int                  samples_taken;
    int                  primes_taken;
    int                  register_writes;

    function new();
      foreach (window_mem[i]) window_mem[i] = '0;
      running_sum      = '0;
      next_slot        = '0;
      average_q        = '0;
      reference_q      = REFERENCE_RESET;
      numerator_q      = NUMERATOR_RESET;
      denominator_q    = DENOMINATOR_RESET;
      offset_q         = OFFSET_RESET;
      mismatches       = 0;
      readings_checked = 0;
      samples_taken    = 0;
      primes_taken     = 0;
      register_writes  = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] index,
                                 logic [CFG_DATA_W-1:0] value);
      register_writes++;
      case (index)
        CFG_REFERENCE_MV:    reference_q = value;
        CFG_DIV_NUMERATOR:   numerator_q = value[RATIO_W-1:0];
        CFG_DIV_DENOMINATOR: denominator_q = value[RATIO_W-1:0];
        CFG_OFFSET_MV:       offset_q = value;
        default: ;
      endcase
    endfunction

    function void note_sample(bmam_in_t item);
      bmam_out_t       reading;
      longint unsigned adc;
      longint unsigned mv;
      longint unsigned dv;
      longint unsigned den;
      samples_taken++;
      if (item.req_type == REQ_PRIME) begin
        primes_taken++;
        foreach (window_mem[i]) window_mem[i] = item.sample;
        running_sum = SUM_W'(WINDOW_SIZE * item.sample);
        average_q   = item.sample;
        next_slot   = '0;
      end else begin
        if (next_slot >= WINDOW_SIZE) next_slot = '0;
        // oldest slot leaves the sum, new sample enters
        running_sum = running_sum - window_mem[next_slot] + item.sample;
        window_mem[next_slot] = item.sample;
        next_slot = next_slot + 6'd1;
        if (next_slot >= WINDOW_SIZE) next_slot = '0;
        average_q = SAMPLE_W'(running_sum / WINDOW_SIZE);
      end
      den = denominator_q;
      if (den == 0) den = 1;
      adc = average_q;
      adc = adc * reference_q / FULL_SCALE;
      mv  = adc * numerator_q / den + offset_q;
      if (mv > MV_LIMIT) mv = MV_LIMIT;
      dv = (mv + ROUNDING) / DECI_STEP;
      if (dv > DV_LIMIT) dv = DV_LIMIT;
      reading.average_raw   = average_q;
      reading.battery_mv    = MV_W'(mv);
      reading.battery_deciv = DV_W'(dv);
      expected_readings.push_back(reading);
    endfunction

    task flag_mismatch(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    task check_reading(bmam_out_t got);
      bmam_out_t want;
      if (expected_readings.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected, average_raw %0d",
                                got.average_raw));
        return;
      end
      want = expected_readings.pop_front();
      readings_checked++;
      if (got.average_raw !== want.average_raw)
        flag_mismatch($sformatf("reading %0d average_raw %0d, expected %0d",
                                readings_checked, got.average_raw, want.average_raw));
      if (got.battery_mv !== want.battery_mv)
        flag_mismatch($sformatf("reading %0d battery_mv %0d, expected %0d",
                                readings_checked, got.battery_mv, want.battery_mv));
      if (got.battery_deciv !== want.battery_deciv)
        flag_mismatch($sformatf("reading %0d battery_deciv %0d, expected %0d",
                                readings_checked, got.battery_deciv, want.battery_deciv));
    endtask

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  bmam_in_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  bmam_out_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int idle_pct         = 0;
  int stall_pct        = 0;
  int idle_cycles      = 0;
  int settings_applied = 0;

  window_average_tracker tracker;

  always #5 clk = ~clk;

  battery_moving_average_monitor #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // transactions are taken from the values held just before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) tracker.note_sample(in_data);
      if (out_valid && out_ready) tracker.check_reading(out_data);
    end
    if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
    $display("FAIL battery_moving_average_monitor");
    $finish;
  end

  task automatic send_item(logic req, logic [SAMPLE_W-1:0] value);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: req, sample: value};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_settings(logic [REF_W-1:0] reference, logic [RATIO_W-1:0] numerator,
                                logic [RATIO_W-1:0] denominator,
                                logic [OFFSET_W-1:0] offset, bit with_spare);
    write_reg(CFG_REFERENCE_MV, reference);
    write_reg(CFG_DIV_NUMERATOR, CFG_DATA_W'(numerator));
    write_reg(CFG_DIV_DENOMINATOR, CFG_DATA_W'(denominator));
    write_reg(CFG_OFFSET_MV, offset);
    if (with_spare) begin
      write_reg(CFG_SPARE_FIRST, '1);
      write_reg(CFG_SPARE_LAST, '1);
    end
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // at least one edge passes so the last accepted sample is already predicted
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_W'($urandom_range(15));
      3:       return SAMPLE_W'(4095 - $urandom_range(15));
      default: return SAMPLE_W'($urandom_range(4095));
    endcase
  endfunction

  function automatic logic [RATIO_W-1:0] random_ratio();
    case ($urandom_range(4))
      0:       return '0;
      1:       return RATIO_W'(1);
      2:       return '1;
      default: return RATIO_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [REF_W-1:0] random_word();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return REF_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic run_random_phase(int count);
    int                  n;
    logic [SAMPLE_W-1:0] value;
    n = 0;
    while (n < count) begin
      if ($urandom_range(11) == 0) begin
        // settle the whole window on one level
        value = random_sample();
        repeat (WINDOW_SIZE) send_item(REQ_NORMAL, value);
        n += WINDOW_SIZE;
      end else begin
        send_item(($urandom_range(9) == 0) ? REQ_PRIME : REQ_NORMAL, random_sample());
        n++;
      end
    end
    wait_idle();
  endtask

  initial begin
    tracker = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // cleared ring, fill to full scale, then primes over a part-filled window
    send_item(REQ_NORMAL, '0);
    repeat (WINDOW_SIZE) send_item(REQ_NORMAL, '1);
    send_item(REQ_NORMAL, 12'hAAA);
    send_item(REQ_NORMAL, 12'h555);
    send_item(REQ_PRIME, '0);
    send_item(REQ_PRIME, '1);
    send_item(REQ_NORMAL, '0);
    send_item(REQ_PRIME, 12'hAAA);
    send_item(REQ_NORMAL, 12'h555);
    wait_idle();

    // largest ratio and offset, decivolts saturate
    apply_settings('1, '1, RATIO_W'(1), '1, 1'b1);
    send_item(REQ_PRIME, '1);
    send_item(REQ_NORMAL, '0);
    send_item(REQ_PRIME, 12'd1);
    wait_idle();

    // zero denominator reads as one
    apply_settings(REF_W'(3300), '1, '0, OFFSET_W'(50), 1'b0);
    send_item(REQ_PRIME, '1);
    wait_idle();

    apply_settings('0, '0, RATIO_W'(1), '0, 1'b0);
    send_item(REQ_PRIME, '1);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 65; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      if (p == 0)
        apply_settings(REFERENCE_RESET, NUMERATOR_RESET, DENOMINATOR_RESET, OFFSET_RESET,
                       1'b0);
      else
        apply_settings(random_word(), random_ratio(), random_ratio(), random_word(),
                       $urandom_range(3) == 0);
      run_random_phase(PHASE_ITEMS);
    end

    idle_pct  = 0;
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d samples (%0d primes) and %0d checked readings",
             tracker.samples_taken, tracker.primes_taken, tracker.readings_checked);
    $display("%0d register writes over %0d settings, extremes and zero denominator included",
             tracker.register_writes, settings_applied);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("PASS battery_moving_average_monitor");
    else
      $display("FAIL battery_moving_average_monitor");
    $finish;
  end

endmodule
